>>> sv/psynth_pkg.sv
// package for the pll synthesizer word generator
// holds field widths, register codes, reset values and the word structs
// no dependencies
package psynth_pkg;

    localparam int DIAL_W     = 21;
    localparam int REF_W      = 15;
    localparam int SHIFT_W    = 17;
    localparam int IF_W       = 17;
    localparam int CFG_DATA_W = 17;
    localparam int WORD_W     = 24;
    localparam int F_W        = 23;
    localparam int MAG_W      = 22;
    localparam int B_FIELD_W  = 13;
    localparam int A_FIELD_W  = 6;
    localparam int R_FIELD_W  = 14;
    localparam int BURST_MAX  = 4;
    localparam int CNT_W      = 3;

    localparam int RASTER_KHZ_DEF = 25;
    localparam int PRESCALER_DEF  = 16;

    localparam logic [WORD_W-1:0] FUNC_LATCH_A = 24'h438086;
    localparam logic [WORD_W-1:0] FUNC_LATCH_B = 24'h438082;

    localparam logic [REF_W-1:0]   REF_RESET   = 15'd12000;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(-28000);
    localparam logic [IF_W-1:0]    IF_RESET    = 17'd69300;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_REF   = 2'd0;
    localparam t_cfg_idx CFG_SHIFT = 2'd1;
    localparam t_cfg_idx CFG_IF    = 2'd2;

    localparam logic KIND_TUNE = 1'b0;
    localparam logic KIND_INIT = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [DIAL_W-1:0] dial_khz;
        logic              transmit;
        logic              shift_enable;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] pll_word;
        logic              last;
    } t_out_word;

    // synthesizer frequency as sign and magnitude
    typedef struct packed {
        logic             kind;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_freq;

    // quotients after the raster divisions
    typedef struct packed {
        logic             kind;
        logic             neg;
        logic [MAG_W-1:0] raster;
        logic [MAG_W-1:0] b_cnt;
        logic [REF_W-1:0] r_cnt;
    } t_quot;

    typedef struct packed {
        logic [BURST_MAX-1:0][WORD_W-1:0] words;
        logic [CNT_W-1:0]                 cnt;
    } t_burst;

endpackage

>>> sv/psynth_freq.sv
// synthesizer frequency select: receive, transmit, transmit with shift
// produces sign and magnitude of the frequency; uses psynth_pkg
module psynth_freq (
    input  psynth_pkg::t_in_word               i_word,
    input  logic [psynth_pkg::IF_W-1:0]        i_if_khz,
    input  logic [psynth_pkg::SHIFT_W-1:0]     i_shift_khz,
    output psynth_pkg::t_freq                  o_freq
);
    import psynth_pkg::*;

    logic [F_W-1:0] dial_e;
    logic [F_W-1:0] if_e;
    logic [F_W-1:0] shift_e;
    logic [F_W-1:0] f_rx;
    logic [F_W-1:0] f_tx;
    logic [F_W-1:0] f_sel;
    logic [F_W-1:0] f_abs;
    logic           use_rx;

    always_comb begin
        dial_e  = {{(F_W-DIAL_W){1'b0}}, i_word.dial_khz};
        if_e    = {{(F_W-IF_W){1'b0}}, i_if_khz};
        shift_e = {{(F_W-SHIFT_W){i_shift_khz[SHIFT_W-1]}}, i_shift_khz};
        f_rx    = dial_e - if_e;
        f_tx    = dial_e + shift_e;
        // init always programs the receive frequency
        use_rx  = (i_word.kind == KIND_INIT) || !i_word.transmit;
        if (use_rx) begin
            f_sel = f_rx;
        end else if (i_word.shift_enable) begin
            f_sel = f_tx;
        end else begin
            f_sel = dial_e;
        end
        f_abs       = f_sel[F_W-1] ? (~f_sel + 1'b1) : f_sel;
        o_freq.kind = i_word.kind;
        o_freq.neg  = f_sel[F_W-1];
        o_freq.mag  = f_abs[MAG_W-1:0];
    end

endmodule

>>> sv/psynth_div.sv
// raster and prescaler division by reciprocal multiplication, one register stage
// also divides the reference for the r counter; uses psynth_pkg
module psynth_div #(
    parameter int RASTER_KHZ = psynth_pkg::RASTER_KHZ_DEF,
    parameter int PRESCALER  = psynth_pkg::PRESCALER_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  psynth_pkg::t_freq             i_freq,
    input  logic [psynth_pkg::REF_W-1:0]  i_ref_khz,
    output logic                          o_ready,
    output logic                          o_valid,
    output psynth_pkg::t_quot             o_quot,
    input  logic                          i_ready
);
    import psynth_pkg::*;

    localparam int DIV_RAS = RASTER_KHZ;
    localparam int DIV_B   = RASTER_KHZ * PRESCALER;
    localparam int MUL_W   = MAG_W + 2;
    localparam int PROD_W  = MAG_W + MUL_W;
    localparam int SH_RAS  = MAG_W + $clog2(DIV_RAS);
    localparam int SH_B    = MAG_W + $clog2(DIV_B);
    localparam logic [63:0] M_RAS_FULL =
        ((64'd1 << SH_RAS) + 64'(DIV_RAS) - 64'd1) / 64'(DIV_RAS);
    localparam logic [63:0] M_B_FULL =
        ((64'd1 << SH_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B);
    localparam logic [MUL_W-1:0] M_RAS = MUL_W'(M_RAS_FULL);
    localparam logic [MUL_W-1:0] M_B   = MUL_W'(M_B_FULL);

    localparam int RMUL_W  = REF_W + 2;
    localparam int RPROD_W = REF_W + RMUL_W;
    localparam int SH_REF  = REF_W + $clog2(DIV_RAS);
    localparam logic [63:0] M_REF_FULL =
        ((64'd1 << SH_REF) + 64'(DIV_RAS) - 64'd1) / 64'(DIV_RAS);
    localparam logic [RMUL_W-1:0] M_REF = RMUL_W'(M_REF_FULL);

    logic [PROD_W-1:0]  prod_ras;
    logic [PROD_W-1:0]  prod_b;
    logic [RPROD_W-1:0] prod_ref;
    t_quot              n_quot;
    logic               r_valid;
    t_quot              r_quot;

    always_comb begin
        prod_ras = PROD_W'(i_freq.mag) * PROD_W'(M_RAS);
        prod_b   = PROD_W'(i_freq.mag) * PROD_W'(M_B);
        prod_ref = RPROD_W'(i_ref_khz) * RPROD_W'(M_REF);
        n_quot.kind   = i_freq.kind;
        n_quot.neg    = i_freq.neg;
        n_quot.raster = MAG_W'(prod_ras >> SH_RAS);
        n_quot.b_cnt  = MAG_W'(prod_b >> SH_B);
        n_quot.r_cnt  = REF_W'(prod_ref >> SH_REF);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quot <= n_quot;
        end
    end

endmodule

>>> sv/psynth_pack.sv
// latch word assembly: n word fields, r word, init sequence of four words
// combinational, fed by the division stage; uses psynth_pkg
module psynth_pack #(
    parameter int PRESCALER = psynth_pkg::PRESCALER_DEF
) (
    input  psynth_pkg::t_quot  i_quot,
    output psynth_pkg::t_burst o_burst
);
    import psynth_pkg::*;

    localparam int A_W = $clog2(PRESCALER);
    localparam logic [A_W-1:0] P_LO = A_W'(PRESCALER);

    logic [2*A_W-1:0]     bp;
    logic [A_W-1:0]       a_mag;
    logic [A_FIELD_W-1:0] a_ext;
    logic [A_FIELD_W-1:0] a_fld;
    logic [B_FIELD_W-1:0] b_fld;
    logic [WORD_W-1:0]    n_word;
    logic [WORD_W-1:0]    r_word;

    always_comb begin
        // remainder only needs the low bits
        bp    = {{A_W{1'b0}}, i_quot.b_cnt[A_W-1:0]} * {{A_W{1'b0}}, P_LO};
        a_mag = i_quot.raster[A_W-1:0] - bp[A_W-1:0];
        a_ext = A_FIELD_W'(a_mag);
        a_fld = i_quot.neg ? (~a_ext + 1'b1) : a_ext;
        b_fld = i_quot.neg ? (~i_quot.b_cnt[B_FIELD_W-1:0] + 1'b1)
                           : i_quot.b_cnt[B_FIELD_W-1:0];
        n_word = {3'b000, b_fld, a_fld, 2'b01};
        r_word = {6'b000000, 2'b10, i_quot.r_cnt[R_FIELD_W-1:0], 2'b00};
        if (i_quot.kind == KIND_INIT) begin
            o_burst.words[0] = FUNC_LATCH_A;
            o_burst.words[1] = r_word;
            o_burst.words[2] = n_word;
            o_burst.words[3] = FUNC_LATCH_B;
            o_burst.cnt      = CNT_W'(BURST_MAX);
        end else begin
            o_burst.words[0] = n_word;
            o_burst.words[1] = n_word;
            o_burst.words[2] = n_word;
            o_burst.words[3] = n_word;
            o_burst.cnt      = CNT_W'(1);
        end
    end

endmodule

>>> sv/psynth_seq.sv
// output buffer that sends a run of one to four words, one per cycle unless stalled
// takes the next run while the last word of the current one leaves; uses psynth_pkg
module psynth_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load_valid,
    input  psynth_pkg::t_burst    i_burst,
    output logic                  o_load_ready,
    output logic                  o_valid,
    output psynth_pkg::t_out_word o_data,
    input  logic                  i_stall
);
    import psynth_pkg::*;

    logic [WORD_W-1:0] r_words [BURST_MAX];
    logic [CNT_W-1:0]  r_cnt;
    logic              emit;
    logic              load;

    assign emit         = (r_cnt != '0) && !i_stall;
    assign o_load_ready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && emit);
    assign load         = i_load_valid && o_load_ready;

    assign o_valid          = (r_cnt != '0);
    assign o_data.pll_word  = r_words[0];
    assign o_data.last      = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= i_burst.cnt;
        end else if (emit) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < BURST_MAX; i++) begin
                r_words[i] <= i_burst.words[i];
            end
        end else if (emit) begin
            for (int i = 0; i < BURST_MAX - 1; i++) begin
                r_words[i] <= r_words[i+1];
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BURST_MAX))
        else $error("word count out of range");

    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_cnt == CNT_W'(1)) || (r_cnt == CNT_W'(BURST_MAX)))
        else $error("run loaded with a bad length");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && i_stall |=> r_cnt == $past(r_cnt))
        else $error("word count moved while stalled");

endmodule

>>> sv/pll_synth_word_generator.sv
// top level of the pll synthesizer word generator
// instantiates psynth_freq, psynth_div, psynth_pack, psynth_seq; uses psynth_pkg
//
// Each accepted word carries a dial frequency and flags and produces the 24-bit
// latch words for a dual-modulus pll: one n word for a tune, or function latch,
// r word, n word at the receive frequency and second function latch for an init.
// Input register, division register and output buffer carry each accepted word in that
// order. A new word can be taken every cycle while o_stall is low; the output buffer
// sends one latch word per cycle while i_stall is low, so tunes run at one per cycle
// and an init occupies the output for its four latch words. Configuration writes are
// always ready and take effect on words accepted after the write while the block is
// empty.
module pll_synth_word_generator #(
    parameter int RASTER_KHZ = psynth_pkg::RASTER_KHZ_DEF,
    parameter int PRESCALER  = psynth_pkg::PRESCALER_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  psynth_pkg::t_in_word               i_data,
    output logic                               o_stall,
    output logic                               o_valid,
    output psynth_pkg::t_out_word              o_data,
    input  logic                               i_stall,
    input  logic                               i_cfg_valid,
    input  psynth_pkg::t_cfg_idx               i_cfg_index,
    input  logic [psynth_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                               o_cfg_ready
);
    import psynth_pkg::*;

    logic [REF_W-1:0]   r_ref_khz;
    logic [SHIFT_W-1:0] r_shift_khz;
    logic [IF_W-1:0]    r_if_khz;
    logic               cfg_wr;

    t_freq  n_s1;
    t_freq  r_s1;
    logic   r_s1_valid;
    logic   div_ready;
    logic   div_valid;
    t_quot  div_quot;
    t_burst burst;
    logic   seq_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_khz   <= REF_RESET;
            r_shift_khz <= SHIFT_RESET;
            r_if_khz    <= IF_RESET;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_REF:   r_ref_khz   <= i_cfg_data[REF_W-1:0];
                CFG_SHIFT: r_shift_khz <= i_cfg_data[SHIFT_W-1:0];
                CFG_IF:    r_if_khz    <= i_cfg_data[IF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    psynth_freq u_freq (
        .i_word      (i_data),
        .i_if_khz    (r_if_khz),
        .i_shift_khz (r_shift_khz),
        .o_freq      (n_s1)
    );

    assign o_stall = r_s1_valid && !div_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_s1 <= n_s1;
        end
    end

    psynth_div #(
        .RASTER_KHZ (RASTER_KHZ),
        .PRESCALER  (PRESCALER)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_valid),
        .i_freq    (r_s1),
        .i_ref_khz (r_ref_khz),
        .o_ready   (div_ready),
        .o_valid   (div_valid),
        .o_quot    (div_quot),
        .i_ready   (seq_ready)
    );

    psynth_pack #(
        .PRESCALER (PRESCALER)
    ) u_pack (
        .i_quot  (div_quot),
        .o_burst (burst)
    );

    psynth_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (div_valid),
        .i_burst      (burst),
        .o_load_ready (seq_ready),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .i_stall      (i_stall)
    );

    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_s1_valid)
        else $error("accepted word lost at input register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && !div_ready)
        else $error("input stalled with nothing pending");

    a_cfg_if: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && (i_cfg_index == CFG_IF) |=> r_if_khz == $past(i_cfg_data[IF_W-1:0]))
        else $error("if offset write not taken");

endmodule

>>> test/tb_pll_synth_word_generator.sv
// testbench for pll_synth_word_generator: directed and random tune and init words
// predicts the latch words from a local copy of the registers and checks every output word
// depends on psynth_pkg and the pll_synth_word_generator rtl
module tb_pll_synth_word_generator;
    import psynth_pkg::*;

    localparam int RASTER       = RASTER_KHZ_DEF;
    localparam int PRESC        = PRESCALER_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_LEN     = 150;
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_in_word              i_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out_word             o_data;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_REF;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_cfg_ready;

    // register shadows
    logic [REF_W-1:0]   ref_sh   = REF_RESET;
    logic [SHIFT_W-1:0] shift_sh = SHIFT_RESET;
    logic [IF_W-1:0]    if_sh    = IF_RESET;

    t_out_word pending_words[$];

    int in_idle_pct  = 23;
    int out_idle_pct = 23;
    int hold_seq     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int n_items      = 0;
    int n_inits      = 0;
    int n_words      = 0;
    int n_cfg        = 0;
    int n_errors     = 0;

    pll_synth_word_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] n_counter_word(input longint f);
        longint raster, b_cnt, a_cnt;
        raster = f / RASTER;
        b_cnt  = raster / PRESC;
        a_cnt  = raster % PRESC;
        return {3'b000, b_cnt[B_FIELD_W-1:0], a_cnt[A_FIELD_W-1:0], 2'b01};
    endfunction

    function automatic logic [WORD_W-1:0] r_counter_word();
        logic [R_FIELD_W-1:0] r_cnt;
        r_cnt = R_FIELD_W'(ref_sh / RASTER);
        return {6'b000000, 2'b10, r_cnt, 2'b00};
    endfunction

    // expected latch words for one accepted word
    function automatic void queue_latch_words(input t_in_word w);
        longint dial, rx_f, f;
        dial = longint'(w.dial_khz);
        rx_f = dial - longint'(if_sh);
        if (w.kind == KIND_INIT) begin
            pending_words.push_back('{pll_word: FUNC_LATCH_A, last: 1'b0});
            pending_words.push_back('{pll_word: r_counter_word(), last: 1'b0});
            pending_words.push_back('{pll_word: n_counter_word(rx_f), last: 1'b0});
            pending_words.push_back('{pll_word: FUNC_LATCH_B, last: 1'b1});
        end else begin
            f = rx_f;
            if (w.transmit) begin
                f = dial;
                if (w.shift_enable) f = f + longint'($signed(shift_sh));
            end
            pending_words.push_back('{pll_word: n_counter_word(f), last: 1'b1});
        end
    endfunction

    function automatic t_in_word make_word(input logic kind, input longint dial,
                                           input logic tx, input logic shen);
        t_in_word w;
        w.kind         = kind;
        w.dial_khz     = DIAL_W'(dial);
        w.transmit     = tx;
        w.shift_enable = shen;
        return w;
    endfunction

    function automatic t_in_word random_word(input int init_pct);
        longint dial;
        case ($urandom_range(3))
            0: dial = $urandom_range(0, 2097151);
            1: begin
                dial = longint'(if_sh) + $urandom_range(0, 4000) - 2000;
                if (dial < 0) dial = 0;
            end
            2: dial = $urandom_range(1240000, 1300000);
            default: dial = $urandom_range(0, 5000);
        endcase
        return make_word(($urandom_range(99) < init_pct) ? KIND_INIT : KIND_TUNE, dial,
                         1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // receiver: random stall, or a long hold-off when the test asks
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // output word checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_words++;
            if (pending_words.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word expected none actual %06h last %0b",
                         $time, o_data.pll_word, o_data.last);
            end else begin
                want = pending_words.pop_front();
                if (o_data.pll_word !== want.pll_word) begin
                    n_errors++;
                    $display("%0t: pll_word mismatch expected %06h actual %06h",
                             $time, want.pll_word, o_data.pll_word);
                end
                if (o_data.last !== want.last) begin
                    n_errors++;
                    $display("%0t: last mismatch expected %0b actual %0b",
                             $time, want.last, o_data.last);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d words still outstanding", $time, pending_words.size());
            $display("pll_synth_word_generator verification failed");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        queue_latch_words(w);
        n_items++;
        if (w.kind == KIND_INIT) n_inits++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_REF:   ref_sh   = val[REF_W-1:0];
            CFG_SHIFT: shift_sh = val[SHIFT_W-1:0];
            CFG_IF:    if_sh    = val[IF_W-1:0];
            default: ;
        endcase
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] ref_v,
                             input logic [CFG_DATA_W-1:0] shift_v,
                             input logic [CFG_DATA_W-1:0] if_v);
        write_reg(CFG_REF, ref_v);
        write_reg(CFG_SHIFT, shift_v);
        write_reg(CFG_IF, if_v);
    endtask

    // reset register values, field extremes, negative and zero frequencies
    task automatic test_reset_config();
        send_word(make_word(KIND_TUNE, 0, 1'b0, 1'b0));
        send_word(make_word(KIND_TUNE, 2097151, 1'b0, 1'b0));
        send_word(make_word(KIND_TUNE, 1296000, 1'b1, 1'b0));
        send_word(make_word(KIND_TUNE, 1298000, 1'b1, 1'b1));
        send_word(make_word(KIND_TUNE, 1296000, 1'b0, 1'b1));
        send_word(make_word(KIND_INIT, 1296000, 1'b1, 1'b1));
        send_word(make_word(KIND_INIT, 0, 1'b0, 1'b0));
        send_word(make_word(KIND_TUNE, 0, 1'b1, 1'b1));
        send_word(make_word(KIND_TUNE, 69300, 1'b0, 1'b0));
        send_word(make_word(KIND_TUNE, 69276, 1'b0, 1'b0));
        send_word(make_word(KIND_TUNE, 69275, 1'b0, 1'b0));
        wait_drained();
    endtask

    // register extremes, oversized data and an unused index
    task automatic test_register_extremes();
        write_all(17'd2000, 17'(60000), 17'd0);
        send_word(make_word(KIND_INIT, 1296000, 1'b0, 1'b0));
        send_word(make_word(KIND_TUNE, 2097151, 1'b1, 1'b1));
        send_word(make_word(KIND_TUNE, 0, 1'b0, 1'b1));
        wait_drained();
        write_all(17'h1ffff, 17'h10000, 17'h1ffff);
        send_word(make_word(KIND_INIT, 0, 1'b1, 1'b0));
        send_word(make_word(KIND_TUNE, 0, 1'b1, 1'b1));
        send_word(make_word(KIND_TUNE, 2097151, 1'b1, 1'b1));
        wait_drained();
        write_reg(CFG_UNUSED, 17'h0aaaa);
        send_word(make_word(KIND_TUNE, 1000000, 1'b0, 1'b0));
        wait_drained();
        write_all(17'd32700, 17'(-60000), 17'd131071);
        send_word(make_word(KIND_INIT, 1296000, 1'b0, 1'b1));
        send_word(make_word(KIND_TUNE, 1296000, 1'b1, 1'b1));
        wait_drained();
    endtask

    // random words under random register settings, one phase with no idling
    task automatic test_random_phases();
        for (int ph = 0; ph < 4; ph++) begin
            write_all(17'($urandom_range(20, 327) * 100),
                      17'(int'($urandom_range(0, 120000)) - 60000),
                      17'($urandom_range(0, 131071)));
            in_idle_pct  = (ph == 2) ? 0 : 23;
            out_idle_pct = (ph == 2) ? 0 : 23;
            for (int k = 0; k < 45; k++) begin
                if (k == 22) wait_drained();
                send_word(random_word(25));
            end
            wait_drained();
        end
        in_idle_pct  = 23;
        out_idle_pct = 23;
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        write_all(17'd12000, 17'(-28000), 17'd69300);
        in_idle_pct = 0;
        hold_seq++;
        for (int k = 0; k < 24; k++) send_word(random_word(40));
        in_idle_pct = 23;
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        wait_drained();
        $display("covered %0d words in (%0d init) and %0d latch words out",
                 n_items, n_inits, n_words);
        $display("with %0d register writes, a long output hold-off and idle pauses", n_cfg);
        if (n_errors == 0)
            $display("pll_synth_word_generator verification clean");
        else
            $display("pll_synth_word_generator verification failed");
        $finish;
    end

endmodule
